// ===== rtl/tlbs_pkg.sv =====
`timescale 1ns / 1ps

package tlbs_pkg;

    // fixed widths from the field definitions
    localparam int CFG_DATA_BITS   = 64;
    localparam int CFG_ADDR_BITS   = 6;
    localparam int STAGE_BITS      = 3;
    localparam int FIELD_BITS      = 16;
    localparam int DEF_PERIOD_BITS = 16;

    // highest stage count the period tables hold
    localparam logic [3:0] NUM_STAGES = 4'd8;

    // register indexes (byte address is 8 * index)
    localparam logic [2:0] REG_PERIOD_LOW  = 3'd0;
    localparam logic [2:0] REG_PERIOD_HIGH = 3'd1;
    localparam logic [2:0] REG_STAGE_COUNT = 3'd2;
    localparam logic [2:0] REG_SECOND_FROM = 3'd3;
    localparam logic [2:0] REG_MODE_COUNT  = 3'd4;

    // register reset values
    localparam logic [63:0] RST_PERIOD_LOW  = 64'h00C8_012C_00C8_012C;
    localparam logic [63:0] RST_PERIOD_HIGH = 64'h012C_0190_00C8_012C;
    localparam logic [3:0]  RST_STAGE_COUNT = 4'd8;
    localparam logic [3:0]  RST_SECOND_FROM = 4'd6;
    localparam logic [1:0]  RST_MODE_COUNT  = 2'd3;

    // operation codes
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_BUTTON = 1'b1;

    // mode codes
    localparam logic [1:0] MODE_OFF     = 2'd0;
    localparam logic [1:0] MODE_BREATHE = 2'd1;
    localparam logic [1:0] MODE_STEADY  = 2'd2;

    typedef struct packed {
        logic [63:0] period_low;
        logic [63:0] period_high;
        logic [3:0]  stage_count;
        logic [3:0]  second_from;
        logic [1:0]  mode_count;
    } t_cfg;

    typedef struct packed {
        logic       pin_a;
        logic       pin_b;
        logic [1:0] mode;
    } t_res;

endpackage

// ===== rtl/tlbs_cfg.sv =====
`timescale 1ns / 1ps

module tlbs_cfg (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [tlbs_pkg::CFG_ADDR_BITS-1:0]    paddr,
    input  logic [tlbs_pkg::CFG_DATA_BITS-1:0]    pwdata,
    output logic [tlbs_pkg::CFG_DATA_BITS-1:0]    prdata,
    output logic                                  pready,
    output tlbs_pkg::t_cfg                        o_cfg
);
    import tlbs_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[CFG_ADDR_BITS-1:3];
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_low  <= RST_PERIOD_LOW;
            r_cfg.period_high <= RST_PERIOD_HIGH;
            r_cfg.stage_count <= RST_STAGE_COUNT;
            r_cfg.second_from <= RST_SECOND_FROM;
            r_cfg.mode_count  <= RST_MODE_COUNT;
        end else if (wr_en) begin
            case (reg_idx)
                REG_PERIOD_LOW:  r_cfg.period_low  <= pwdata;
                REG_PERIOD_HIGH: r_cfg.period_high <= pwdata;
                REG_STAGE_COUNT: r_cfg.stage_count <= pwdata[3:0];
                REG_SECOND_FROM: r_cfg.second_from <= pwdata[3:0];
                REG_MODE_COUNT:  r_cfg.mode_count  <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PERIOD_LOW:  prdata = r_cfg.period_low;
            REG_PERIOD_HIGH: prdata = r_cfg.period_high;
            REG_STAGE_COUNT: prdata = {60'd0, r_cfg.stage_count};
            REG_SECOND_FROM: prdata = {60'd0, r_cfg.second_from};
            REG_MODE_COUNT:  prdata = {62'd0, r_cfg.mode_count};
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== rtl/tlbs_core.sv =====
`timescale 1ns / 1ps

module tlbs_core #(
    parameter int PERIOD_BITS = tlbs_pkg::DEF_PERIOD_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_advance,
    input  logic           i_op,
    input  logic           i_first_sample_low,
    input  logic           i_second_sample_low,
    input  tlbs_pkg::t_cfg i_cfg,
    output tlbs_pkg::t_res o_res
);
    import tlbs_pkg::*;

    // state
    logic [1:0]             r_mode,   n_mode;
    logic [STAGE_BITS-1:0]  r_stage,  n_stage;
    logic [PERIOD_BITS-1:0] r_tick,   n_tick;
    logic [PERIOD_BITS-1:0] r_duty,   n_duty;
    logic                   r_bright, n_bright;
    logic                   r_second, n_second;
    logic                   r_pin_a,  n_pin_a;
    logic                   r_pin_b,  n_pin_b;

    // breathing step
    logic [63:0]            period_word;
    logic [FIELD_BITS-1:0]  period_field;
    logic [PERIOD_BITS-1:0] period;
    logic [PERIOD_BITS:0]   duty_sum;
    logic [STAGE_BITS:0]    stage_sum;
    logic [3:0]             stage_lim;
    logic [2:0]             mode_sum;
    logic [1:0]             mode_lim;
    logic [PERIOD_BITS-1:0] b_tick;
    logic [PERIOD_BITS-1:0] b_duty;
    logic [STAGE_BITS-1:0]  b_stage;
    logic                   b_bright;
    logic                   b_second;
    logic                   b_pin_a;
    logic                   b_pin_b;
    logic                   lit;

    // period of the current stage, zero counts as one
    always_comb begin
        period_word = r_stage[2] ? i_cfg.period_high : i_cfg.period_low;
        case (r_stage[1:0])
            2'd0:    period_field = period_word[15:0];
            2'd1:    period_field = period_word[31:16];
            2'd2:    period_field = period_word[47:32];
            default: period_field = period_word[63:48];
        endcase
        period = period_field[PERIOD_BITS-1:0];
        if (period == '0) begin
            period = {{(PERIOD_BITS-1){1'b0}}, 1'b1};
        end
    end

    always_comb begin
        if (i_cfg.stage_count == 4'd0) begin
            stage_lim = 4'd1;
        end else if (i_cfg.stage_count > NUM_STAGES) begin
            stage_lim = NUM_STAGES;
        end else begin
            stage_lim = i_cfg.stage_count;
        end
        mode_lim  = (i_cfg.mode_count == 2'd0) ? 2'd1 : i_cfg.mode_count;
        duty_sum  = {1'b0, r_duty} + {{PERIOD_BITS{1'b0}}, 1'b1};
        stage_sum = {1'b0, r_stage} + {{STAGE_BITS{1'b0}}, 1'b1};
        mode_sum  = {1'b0, r_mode} + 3'd1;
    end

    // one breathing tick
    always_comb begin
        b_tick   = r_tick;
        b_duty   = r_duty;
        b_stage  = r_stage;
        b_bright = r_bright;
        b_second = r_second;
        b_pin_a  = r_pin_a;
        b_pin_b  = r_pin_b;
        if (r_tick >= period) begin
            b_tick = '0;
            if (duty_sum >= {1'b0, period}) begin
                // duty wrapped: flip direction, next stage
                b_duty   = '0;
                b_bright = ~r_bright;
                b_stage  = (stage_sum >= stage_lim) ? '0 : stage_sum[STAGE_BITS-1:0];
                if ({1'b0, b_stage} >= i_cfg.second_from) begin
                    b_second = 1'b1;
                    b_pin_a  = 1'b1;
                end else begin
                    b_second = 1'b0;
                    b_pin_b  = 1'b1;
                end
            end else begin
                b_duty = duty_sum[PERIOD_BITS-1:0];
            end
        end
        // brightening drives the pin low while below duty
        lit = (b_tick < b_duty) ^ b_bright;
        if (b_second) begin
            b_pin_b = lit;
        end else begin
            b_pin_a = lit;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_stage  = r_stage;
        n_tick   = r_tick;
        n_duty   = r_duty;
        n_bright = r_bright;
        n_second = r_second;
        n_pin_a  = r_pin_a;
        n_pin_b  = r_pin_b;
        if (i_op == OP_BUTTON) begin
            if (i_first_sample_low && i_second_sample_low) begin
                n_mode = (mode_sum >= {1'b0, mode_lim}) ? MODE_OFF : mode_sum[1:0];
            end
        end else begin
            case (r_mode)
                MODE_OFF: begin
                    n_pin_a = 1'b1;
                    n_pin_b = 1'b1;
                end
                MODE_BREATHE: begin
                    n_stage  = b_stage;
                    n_tick   = b_tick + {{(PERIOD_BITS-1){1'b0}}, 1'b1};
                    n_duty   = b_duty;
                    n_bright = b_bright;
                    n_second = b_second;
                    n_pin_a  = b_pin_a;
                    n_pin_b  = b_pin_b;
                end
                MODE_STEADY: begin
                    n_pin_a = 1'b1;
                    n_pin_b = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_OFF;
            r_stage  <= '0;
            r_tick   <= '0;
            r_duty   <= '0;
            r_bright <= 1'b1;
            r_second <= 1'b0;
            r_pin_a  <= 1'b1;
            r_pin_b  <= 1'b1;
        end else if (i_advance) begin
            r_mode   <= n_mode;
            r_stage  <= n_stage;
            r_tick   <= n_tick;
            r_duty   <= n_duty;
            r_bright <= n_bright;
            r_second <= n_second;
            r_pin_a  <= n_pin_a;
            r_pin_b  <= n_pin_b;
        end
    end

    assign o_res.pin_a = n_pin_a;
    assign o_res.pin_b = n_pin_b;
    assign o_res.mode  = n_mode;

endmodule

// ===== rtl/two_led_breathing_sequencer_top.sv =====
`timescale 1ns / 1ps
// two-led breathing sequencer
// input channel (i_in_valid / o_in_ready) carries one beat per main-loop tick
// or button event: i_op, i_first_sample_low, i_second_sample_low
// output channel (o_out_valid / i_out_ready) returns exactly one beat per
// input beat: both active-low pin levels and the mode after that step
// an input beat is registered in the input register; the sequencer state and
// the result register then update together once the result register is free
// or draining, so a receiver stall can hold the beat in the input register
// throughput is one beat per cycle while results are taken; the state update
// (period compare, duty and stage increment-and-wrap) is combinational logic
// when the receiver stalls, the result register holds its beat and the input
// register can still take one more beat; only then does o_in_ready drop
// reset (synchronous, active low) empties both registers, puts the block in
// mode off with both pins high, and loads the default period table,
// stage count, second-led threshold and mode count
// the apb-style port at byte address 8*index writes and reads the registers;
// write only while no beat is in flight
module two_led_breathing_sequencer_top #(
    parameter int PERIOD_BITS = tlbs_pkg::DEF_PERIOD_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_op,
    input  logic                               i_first_sample_low,
    input  logic                               i_second_sample_low,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_led_a_level,
    output logic                               o_led_b_level,
    output logic [1:0]                         o_current_mode,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tlbs_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [tlbs_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [tlbs_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                               pready
);
    import tlbs_pkg::*;

    t_cfg cfg;
    t_res res;

    // input register
    logic r_in_valid, n_in_valid;
    logic r_op;
    logic r_s1;
    logic r_s2;

    // result register
    logic r_out_valid, n_out_valid;
    t_res r_out;

    logic in_fire;
    logic advance;

    // the held beat moves on when the result register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_fire) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op <= i_op;
            r_s1 <= i_first_sample_low;
            r_s2 <= i_second_sample_low;
        end
        if (advance) begin
            r_out <= res;
        end
    end

    tlbs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tlbs_core #(
        .PERIOD_BITS (PERIOD_BITS)
    ) u_core (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_advance           (advance),
        .i_op                (r_op),
        .i_first_sample_low  (r_s1),
        .i_second_sample_low (r_s2),
        .i_cfg               (cfg),
        .o_res               (res)
    );

    assign o_out_valid    = r_out_valid;
    assign o_led_a_level  = r_out.pin_a;
    assign o_led_b_level  = r_out.pin_b;
    assign o_current_mode = r_out.mode;

endmodule

// ===== rtl/tlbs_checker.sv =====
`timescale 1ns / 1ps

module tlbs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_led_a_level,
    input logic       o_led_b_level,
    input logic [1:0] o_current_mode
);

    // a stalled result stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_led_a_level) && $stable(o_led_b_level) && $stable(o_current_mode))
        else $error("result payload changed while stalled");

    // with the result register empty the input side never blocks
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

    // mode never reaches the unused code
    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_current_mode != 2'd3)
        else $error("mode out of range");

    // reset empties the output side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind two_led_breathing_sequencer_top tlbs_checker u_tlbs_checker (.*);

// ===== tb/two_led_breathing_sequencer_top_test.sv =====
`timescale 1ns / 1ps
module two_led_breathing_sequencer_top_test;
    import tlbs_pkg::*;

    // run ends here even if a handshake hangs
    localparam longint LIMIT_NS = 64'd12_000_000;
    localparam int     NUM_ROWS = 20;
    localparam int     NUM_SETTINGS = 6;

    // clock, reset and every block input start at known values
    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic                     i_op = OP_TICK;
    logic                     i_first_sample_low = 1'b0;
    logic                     i_second_sample_low = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic                     o_led_a_level;
    logic                     o_led_b_level;
    logic [1:0]               o_current_mode;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr = '0;
    logic [CFG_DATA_BITS-1:0] pwdata = '0;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    two_led_breathing_sequencer_top DUT (.*);

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // a directed row may carry a result typed in by hand; the rest use the predictor
    typedef struct packed {
        logic op;
        logic s1;
        logic s2;
        logic checked;
        t_res leds;
    } t_dir_row;

    // one register setting of the random part
    typedef struct packed {
        logic [63:0] period_low;
        logic [63:0] period_high;
        logic [3:0]  stages;
        logic [3:0]  second_from;
        logic [1:0]  modes;
        logic [15:0] beats;
        logic [7:0]  button_pct;
        logic        shuffle;
    } t_setting;

    // reset state, then every operation and sample combination, then a full mode cycle
    t_dir_row dir_rows [0:NUM_ROWS-1] = '{
        '{OP_TICK,   1'b0, 1'b0, 1'b1, '{1'b1, 1'b1, MODE_OFF}},
        '{OP_BUTTON, 1'b1, 1'b0, 1'b1, '{1'b1, 1'b1, MODE_OFF}},
        '{OP_BUTTON, 1'b0, 1'b1, 1'b1, '{1'b1, 1'b1, MODE_OFF}},
        '{OP_BUTTON, 1'b0, 1'b0, 1'b1, '{1'b1, 1'b1, MODE_OFF}},
        '{OP_BUTTON, 1'b1, 1'b1, 1'b1, '{1'b1, 1'b1, MODE_BREATHE}},
        '{OP_TICK,   1'b1, 1'b1, 1'b0, '{1'b0, 1'b0, MODE_OFF}},
        '{OP_TICK,   1'b0, 1'b1, 1'b0, '{1'b0, 1'b0, MODE_OFF}},
        '{OP_TICK,   1'b1, 1'b0, 1'b0, '{1'b0, 1'b0, MODE_OFF}},
        '{OP_TICK,   1'b0, 1'b0, 1'b0, '{1'b0, 1'b0, MODE_OFF}},
        '{OP_BUTTON, 1'b1, 1'b0, 1'b0, '{1'b0, 1'b0, MODE_OFF}},
        '{OP_BUTTON, 1'b1, 1'b1, 1'b0, '{1'b0, 1'b0, MODE_OFF}},
        '{OP_TICK,   1'b0, 1'b0, 1'b1, '{1'b1, 1'b0, MODE_STEADY}},
        '{OP_TICK,   1'b1, 1'b1, 1'b1, '{1'b1, 1'b0, MODE_STEADY}},
        '{OP_BUTTON, 1'b1, 1'b1, 1'b1, '{1'b1, 1'b0, MODE_OFF}},
        '{OP_TICK,   1'b0, 1'b0, 1'b1, '{1'b1, 1'b1, MODE_OFF}},
        '{OP_BUTTON, 1'b1, 1'b1, 1'b1, '{1'b1, 1'b1, MODE_BREATHE}},
        '{OP_TICK,   1'b0, 1'b0, 1'b0, '{1'b0, 1'b0, MODE_OFF}},
        '{OP_TICK,   1'b0, 1'b0, 1'b0, '{1'b0, 1'b0, MODE_OFF}},
        '{OP_BUTTON, 1'b1, 1'b1, 1'b0, '{1'b0, 1'b0, MODE_OFF}},
        '{OP_BUTTON, 1'b1, 1'b1, 1'b0, '{1'b0, 1'b0, MODE_OFF}}
    };

    // settings run in order, state carries over from one to the next:
    // - short periods, two of them zero, so stages turn over fast
    // - low stages short, high stages at the full 16-bit period: the stage parks high
    //   and the tick position climbs far
    // - all periods zero and stage count zero: position and stage index now sit past
    //   their limits, mode count two wraps a steady mode back to off
    // - period twelve with stage count above the table: duty climbs high
    // - short periods again, so duty sits past the period; one stage, mode count zero
    // - random short periods and random counts
    t_setting settings [0:NUM_SETTINGS-1] = '{
        '{64'h0002_0001_0003_0000, 64'h0004_0000_0002_0001, 4'd8,  4'd4,  2'd3,
          16'd300, 8'd12, 1'b0},
        '{64'h0001_0002_0001_0000, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  4'd0,  2'd3,
          16'd200, 8'd2,  1'b0},
        '{64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000, 4'd0,  4'd15, 2'd2,
          16'd150, 8'd15, 1'b0},
        '{64'h000C_000C_000C_000C, 64'h000C_000C_000C_000C, 4'd15, 4'd8,  2'd3,
          16'd250, 8'd2,  1'b0},
        '{64'h0003_0002_0003_0001, 64'h0002_0003_0001_0002, 4'd1,  4'd1,  2'd0,
          16'd100, 8'd10, 1'b0},
        '{64'h0, 64'h0, 4'd0, 4'd0, 2'd0, 16'd200, 8'd10, 1'b1}
    };

    // predictor copy of the registers
    logic [63:0] cfg_period_low = RST_PERIOD_LOW;
    logic [63:0] cfg_period_high = RST_PERIOD_HIGH;
    logic [3:0]  cfg_stages = RST_STAGE_COUNT;
    logic [3:0]  cfg_second_from = RST_SECOND_FROM;
    logic [1:0]  cfg_modes = RST_MODE_COUNT;

    // predictor copy of the sequencer state
    logic [1:0]  seq_mode = MODE_OFF;
    logic [2:0]  seq_stage = 3'd0;
    logic [15:0] seq_pos = 16'd0;
    logic [15:0] seq_duty = 16'd0;
    logic        seq_brightening = 1'b1;
    logic        seq_second_led = 1'b0;
    logic        seq_pin_a = 1'b1;
    logic        seq_pin_b = 1'b1;

    // pin levels and mode still to come, oldest first
    t_res expected_leds [$];

    // handed from driver to checker with each beat
    logic        row_checked = 1'b0;
    t_res        row_leds = '0;
    logic        calm = 1'b0;

    int          stall_left = 0;
    int          errors = 0;
    int          n_beats = 0;
    int          n_checked = 0;
    int          n_buttons = 0;
    int          n_mode_changes = 0;
    int          n_breathe_ticks = 0;
    int          n_stage_steps = 0;
    int          n_settings = 0;
    t_res        predicted;
    t_res        want;
    logic [63:0] want_reg;

    // mostly no gap, some short ones, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] stage_period(input logic [2:0] stage);
        logic [63:0] word;
        logic [15:0] p;
        word = stage[2] ? cfg_period_high : cfg_period_low;
        p = word[16*stage[1:0] +: 16];
        return (p == 16'd0) ? 16'd1 : p;
    endfunction

    // one software-pwm tick in breathing mode
    function automatic void breathe_tick();
        logic [15:0] p;
        logic [3:0]  cnt;
        logic        lit;
        p = stage_period(seq_stage);
        // end of period, also when a table change left the position past it
        if (seq_pos >= p) begin
            seq_pos = 16'd0;
            seq_duty = ({1'b0, seq_duty} + 17'd1 >= {1'b0, p}) ? 16'd0 : seq_duty + 16'd1;
            if (seq_duty == 16'd0) begin
                // duty wrapped: flip fade direction and move to the next stage
                cnt = (cfg_stages == 4'd0) ? 4'd1 :
                      (cfg_stages > NUM_STAGES) ? NUM_STAGES : cfg_stages;
                seq_brightening = ~seq_brightening;
                seq_stage = ({1'b0, seq_stage} + 4'd1 >= cnt) ? 3'd0 : seq_stage + 3'd1;
                n_stage_steps++;
                if ({1'b0, seq_stage} >= cfg_second_from) begin
                    seq_second_led = 1'b1;
                    seq_pin_a = 1'b1;
                end else begin
                    seq_second_led = 1'b0;
                    seq_pin_b = 1'b1;
                end
            end
        end
        // below duty the led is lit while brightening, dark while dimming
        lit = (seq_pos < seq_duty) ^ seq_brightening;
        if (seq_second_led) seq_pin_b = lit;
        else seq_pin_a = lit;
        seq_pos = seq_pos + 16'd1;
    endfunction

    // advances the predicted state by one beat and returns the pins and mode after it
    function automatic t_res predict_leds(input logic op, input logic s1, input logic s2);
        t_res        r;
        logic [1:0]  cnt;
        if (op == OP_BUTTON) begin
            n_buttons++;
            // both debounce samples must read pressed; pins hold their levels
            if (s1 && s2) begin
                cnt = (cfg_modes == 2'd0) ? 2'd1 : cfg_modes;
                seq_mode = ({1'b0, seq_mode} + 3'd1 >= {1'b0, cnt}) ? MODE_OFF :
                           seq_mode + 2'd1;
                n_mode_changes++;
            end
        end else begin
            case (seq_mode)
                MODE_OFF: begin
                    seq_pin_a = 1'b1;
                    seq_pin_b = 1'b1;
                end
                MODE_BREATHE: begin
                    n_breathe_ticks++;
                    breathe_tick();
                end
                MODE_STEADY: begin
                    seq_pin_a = 1'b1;
                    seq_pin_b = 1'b0;
                end
                default: ;
            endcase
        end
        r.pin_a = seq_pin_a;
        r.pin_b = seq_pin_b;
        r.mode = seq_mode;
        return r;
    endfunction

    function automatic void note_mismatch(input string what, input logic [63:0] exp_val,
                                          input logic [63:0] got_val);
        errors++;
        if (errors <= 10)
            $display("mismatch after %0d results, %s: expected %0h, got %0h",
                     n_checked, what, exp_val, got_val);
    endfunction

    // receiver: random stalls, none while calm
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (calm) begin
            i_out_ready <= 1'b1;
        end else begin
            stall_left = pick_gap();
            i_out_ready <= (stall_left == 0);
            if (stall_left > 0) stall_left <= stall_left - 1;
        end
    end

    // watches both channels and the register port at every edge, values from before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predicted = predict_leds(i_op, i_first_sample_low, i_second_sample_low);
                expected_leds.push_back(row_checked ? row_leds : predicted);
                n_beats++;
            end
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[5:3])
                        REG_PERIOD_LOW:  cfg_period_low = pwdata;
                        REG_PERIOD_HIGH: cfg_period_high = pwdata;
                        REG_STAGE_COUNT: cfg_stages = pwdata[3:0];
                        REG_SECOND_FROM: cfg_second_from = pwdata[3:0];
                        REG_MODE_COUNT:  cfg_modes = pwdata[1:0];
                        default: ;
                    endcase
                end else begin
                    case (paddr[5:3])
                        REG_PERIOD_LOW:  want_reg = cfg_period_low;
                        REG_PERIOD_HIGH: want_reg = cfg_period_high;
                        REG_STAGE_COUNT: want_reg = {60'd0, cfg_stages};
                        REG_SECOND_FROM: want_reg = {60'd0, cfg_second_from};
                        REG_MODE_COUNT:  want_reg = {62'd0, cfg_modes};
                        default:         want_reg = '0;
                    endcase
                    if (prdata !== want_reg) note_mismatch("register readback", want_reg, prdata);
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_leds.size() == 0) begin
                    note_mismatch("result beat with nothing expected", 64'd0,
                                  {60'd0, o_led_a_level, o_led_b_level, o_current_mode});
                end else begin
                    want = expected_leds.pop_front();
                    if (o_led_a_level !== want.pin_a)
                        note_mismatch("led_a_level", {63'd0, want.pin_a},
                                      {63'd0, o_led_a_level});
                    if (o_led_b_level !== want.pin_b)
                        note_mismatch("led_b_level", {63'd0, want.pin_b},
                                      {63'd0, o_led_b_level});
                    if (o_current_mode !== want.mode)
                        note_mismatch("current_mode", {62'd0, want.mode},
                                      {62'd0, o_current_mode});
                    n_checked++;
                end
            end
        end
    end

    // holds one beat until it is taken, then maybe leaves a gap
    task automatic send_beat(input logic op, input logic s1, input logic s2,
                             input logic checked, input t_res leds);
        int gap;
        i_in_valid <= 1'b1;
        i_op <= op;
        i_first_sample_low <= s1;
        i_second_sample_low <= s2;
        row_checked <= checked;
        row_leds <= leds;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop sending until every result is back, then let the pipeline drain
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_leds.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // setup cycle, then access cycle; psel stays up for back-to-back transfers
    task automatic reg_access(input logic [2:0] idx, input logic [63:0] value,
                              input logic is_write);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    task automatic load_setting(input t_setting s);
        reg_access(REG_PERIOD_LOW, s.period_low, 1'b1);
        reg_access(REG_PERIOD_LOW, 64'd0, 1'b0);
        reg_access(REG_PERIOD_HIGH, s.period_high, 1'b1);
        reg_access(REG_PERIOD_HIGH, 64'd0, 1'b0);
        reg_access(REG_STAGE_COUNT, {60'd0, s.stages}, 1'b1);
        reg_access(REG_STAGE_COUNT, 64'd0, 1'b0);
        reg_access(REG_SECOND_FROM, {60'd0, s.second_from}, 1'b1);
        reg_access(REG_SECOND_FROM, 64'd0, 1'b0);
        reg_access(REG_MODE_COUNT, {62'd0, s.modes}, 1'b1);
        reg_access(REG_MODE_COUNT, 64'd0, 1'b0);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        n_settings++;
    endtask

    initial begin
        t_setting s;
        logic     op;
        logic     s1;
        logic     s2;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows against reset defaults
        for (int r = 0; r < NUM_ROWS; r++)
            send_beat(dir_rows[r].op, dir_rows[r].s1, dir_rows[r].s2,
                      dir_rows[r].checked, dir_rows[r].leds);
        settle();

        for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
            s = settings[ph];
            if (s.shuffle) begin
                for (int j = 0; j < 4; j++) begin
                    s.period_low[16*j +: 16] = 16'($urandom_range(0, 6));
                    s.period_high[16*j +: 16] = 16'($urandom_range(0, 6));
                end
                s.stages = 4'($urandom_range(0, 15));
                s.second_from = 4'($urandom_range(0, 15));
                s.modes = 2'($urandom_range(0, 3));
            end
            // nothing in flight while the registers change
            settle();
            load_setting(s);
            for (int k = 0; k < s.beats; k++) begin
                // odd settings open with a stretch of back-to-back beats on both sides
                calm <= (k < 40) && ph[0];
                // halfway through, hold off until every result is back
                if (k == s.beats / 2) settle();
                op = ($urandom_range(0, 99) < s.button_pct) ? OP_BUTTON : OP_TICK;
                if (op == OP_BUTTON && $urandom_range(0, 99) < 70) begin
                    s1 = 1'b1;
                    s2 = 1'b1;
                end else begin
                    s1 = 1'($urandom_range(0, 1));
                    s2 = 1'($urandom_range(0, 1));
                end
                send_beat(op, s1, s2, 1'b0, '0);
            end
        end
        calm <= 1'b0;
        settle();

        $display("%0d beats over %0d register settings: %0d button events, %0d mode changes",
                 n_beats, n_settings, n_buttons, n_mode_changes);
        $display("%0d breathing ticks, %0d stage advances, %0d results checked, %0d mismatches",
                 n_breathe_ticks, n_stage_steps, n_checked, errors);
        if (errors == 0 && expected_leds.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("timeout with %0d results outstanding", expected_leds.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
